// ===== sv/stm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_pkg: shared types and constants for the threshold monitor
// Register indexes, function codes, stream packing widths and the
// control/result structs passed between pipeline stages.
// ----------------------------------------------------------------------------
package stm_pkg;

	localparam int Q_W          = 32;   // Q16.16 value width
	localparam int PROD_W       = 64;   // full product width
	localparam int HYST_W       = 31;
	localparam int PAIR_W       = 64;
	localparam int NUM_ALARMS   = 6;
	localparam int MAX_LEVELS   = 3;
	localparam int LEVELS_DEFAULT = 3;
	localparam int LEVEL_W      = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int IN_TDATA_W   = 40;
	localparam int OUT_TDATA_W  = 56;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HYST          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WARNING_PAIR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_PAIR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_PAIR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK   = 3'd6;

	// func codes
	localparam logic FUNC_READING = 1'b0;
	localparam logic FUNC_FORCED  = 1'b1;

	// status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
	localparam logic [Q_W-1:0] GAIN_RESET = 32'h0001_0000;

	typedef logic signed [Q_W-1:0] q16_t;

	typedef struct packed {
		logic               func;
		logic               available;
		logic               functional;
		logic [LEVEL_W-1:0] level;
		logic               direction;
		logic               forced_alarm;
	} ctl_t;

	typedef struct packed {
		logic                  status;
		logic                  normal_range_event;
		logic [NUM_ALARMS-1:0] deasserted_events;
		logic [NUM_ALARMS-1:0] asserted_events;
		logic [NUM_ALARMS-1:0] alarm_bits;
		logic                  value_valid;
		q16_t                  scaled_value;
	} res_t;

endpackage

// ===== sv/stm_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_cfg_regs: configuration register file
// Holds gain, offset, hysteresis, per-level thresholds and the enable mask;
// registers the hysteresis release bounds for each threshold.
// ----------------------------------------------------------------------------
module stm_cfg_regs #(
	parameter int LEVELS = stm_pkg::LEVELS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [stm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stm_pkg::PAIR_W-1:0]          cfg_wdata,
	output stm_pkg::q16_t                       gain,
	output stm_pkg::q16_t                       offset,
	output logic [LEVELS-1:0][stm_pkg::Q_W-1:0] hi_th,
	output logic [LEVELS-1:0][stm_pkg::Q_W:0]   hi_clr,
	output logic [LEVELS-1:0][stm_pkg::Q_W-1:0] lo_th,
	output logic [LEVELS-1:0][stm_pkg::Q_W:0]   lo_clr,
	output logic [stm_pkg::NUM_ALARMS-1:0]      enable
);

	localparam logic [stm_pkg::NUM_ALARMS-1:0] LVL_MASK =
		stm_pkg::NUM_ALARMS'((1 << (2 * LEVELS)) - 1);

	stm_pkg::q16_t                       gain_q;
	stm_pkg::q16_t                       offset_q;
	logic [stm_pkg::HYST_W-1:0]          hyst_q;
	logic [LEVELS-1:0][stm_pkg::Q_W-1:0] hi_q;
	logic [LEVELS-1:0][stm_pkg::Q_W-1:0] lo_q;
	logic [LEVELS-1:0][stm_pkg::Q_W:0]   hi_clr_q;
	logic [LEVELS-1:0][stm_pkg::Q_W:0]   lo_clr_q;
	logic [stm_pkg::NUM_ALARMS-1:0]      enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= stm_pkg::GAIN_RESET;
			offset_q <= '0;
			hyst_q   <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			enable_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				stm_pkg::REG_GAIN:        gain_q   <= cfg_wdata[stm_pkg::Q_W-1:0];
				stm_pkg::REG_OFFSET:      offset_q <= cfg_wdata[stm_pkg::Q_W-1:0];
				stm_pkg::REG_HYST:        hyst_q   <= cfg_wdata[stm_pkg::HYST_W-1:0];
				stm_pkg::REG_ENABLE_MASK: enable_q <= cfg_wdata[stm_pkg::NUM_ALARMS-1:0];
				default: ;
			endcase
			// pair registers follow on consecutive indexes, one per level kept
			for (int l = 0; l < LEVELS; l++) begin
				if (int'(cfg_index) == int'(stm_pkg::REG_WARNING_PAIR) + l) begin
					hi_q[l] <= cfg_wdata[stm_pkg::PAIR_W-1:stm_pkg::Q_W];
					lo_q[l] <= cfg_wdata[stm_pkg::Q_W-1:0];
				end
			end
		end
	end

	// release bounds: high clears below th - hyst, low clears above th + hyst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_clr_q <= '0;
			lo_clr_q <= '0;
		end else begin
			for (int l = 0; l < LEVELS; l++) begin
				hi_clr_q[l] <= {hi_q[l][stm_pkg::Q_W-1], hi_q[l]} - {2'b00, hyst_q};
				lo_clr_q[l] <= {lo_q[l][stm_pkg::Q_W-1], lo_q[l]} + {2'b00, hyst_q};
			end
		end
	end

	assign gain   = gain_q;
	assign offset = offset_q;
	assign hi_th  = hi_q;
	assign lo_th  = lo_q;
	assign hi_clr = hi_clr_q;
	assign lo_clr = lo_clr_q;
	assign enable = enable_q & LVL_MASK;

endmodule

// ===== sv/stm_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_mult: reading times gain, registered
// Full 32x32 signed product into the second pipeline stage, with the
// item's control fields carried alongside.
// ----------------------------------------------------------------------------
module stm_mult (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic                                valid_in,
	input  stm_pkg::q16_t                       raw_s1,
	input  stm_pkg::ctl_t                       ctl_s1,
	input  stm_pkg::q16_t                       gain,
	output logic                                valid_s2,
	output logic signed [stm_pkg::PROD_W-1:0]   product_s2,
	output stm_pkg::ctl_t                       ctl_s2
);

	logic signed [stm_pkg::PROD_W-1:0] product;
	logic                              valid_q;

	assign product = raw_s1 * gain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			product_s2 <= product;
			ctl_s2     <= ctl_s1;
		end
	end

	assign valid_s2 = valid_q;

endmodule

// ===== sv/stm_alarm_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_alarm_eval: offset, saturation and threshold evaluation
// Adds the offset, saturates to Q16.16, applies the hysteresis thresholds
// or a forced event, and owns the alarm flag register.
// ----------------------------------------------------------------------------
module stm_alarm_eval #(
	parameter int LEVELS = stm_pkg::LEVELS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                upd,
	input  logic signed [stm_pkg::PROD_W-1:0]   product_s2,
	input  stm_pkg::ctl_t                       ctl_s2,
	input  stm_pkg::q16_t                       offset,
	input  logic [LEVELS-1:0][stm_pkg::Q_W-1:0] hi_th,
	input  logic [LEVELS-1:0][stm_pkg::Q_W:0]   hi_clr,
	input  logic [LEVELS-1:0][stm_pkg::Q_W-1:0] lo_th,
	input  logic [LEVELS-1:0][stm_pkg::Q_W:0]   lo_clr,
	input  logic [stm_pkg::NUM_ALARMS-1:0]      enable,
	output stm_pkg::res_t                       res
);

	localparam int NA = stm_pkg::NUM_ALARMS;

	logic [NA-1:0] alarm_q;
	logic [NA-1:0] alarm_d;

	always_comb begin
		logic signed [stm_pkg::PROD_W-1:0] sum;
		stm_pkg::q16_t                     sat;
		logic signed [stm_pkg::Q_W:0]      v33;
		logic [NA-1:0]                     read_new;
		logic [NA+1:0]                     en8;
		logic [NA+1:0]                     forced8;
		logic [2:0]                        fbit;
		logic                              forced_ok;
		logic                              usable;
		logic [NA-1:0]                     asr;
		logic [NA-1:0]                     dsr;
		logic [NA-1:0]                     low_m;
		logic                              nr;

		sum = product_s2 + {{(stm_pkg::PROD_W - stm_pkg::Q_W){offset[stm_pkg::Q_W-1]}}, offset};
		if (~|sum[stm_pkg::PROD_W-1:stm_pkg::Q_W-1] || &sum[stm_pkg::PROD_W-1:stm_pkg::Q_W-1]) begin
			sat = sum[stm_pkg::Q_W-1:0];
		end else if (sum[stm_pkg::PROD_W-1]) begin
			sat = stm_pkg::Q_MIN;
		end else begin
			sat = stm_pkg::Q_MAX;
		end
		v33 = {sat[stm_pkg::Q_W-1], sat};

		// hysteresis compare per threshold; even bit high, odd bit low
		read_new = alarm_q;
		for (int l = 0; l < LEVELS; l++) begin
			if (enable[2*l]) begin
				if (sat >= $signed(hi_th[l]))
					read_new[2*l] = 1'b1;
				else if (v33 < $signed(hi_clr[l]))
					read_new[2*l] = 1'b0;
			end
			if (enable[2*l+1]) begin
				if (sat <= $signed(lo_th[l]))
					read_new[2*l+1] = 1'b1;
				else if (v33 > $signed(lo_clr[l]))
					read_new[2*l+1] = 1'b0;
			end
		end

		fbit      = {ctl_s2.level, ctl_s2.direction};
		en8       = {2'b00, enable};
		forced_ok = (ctl_s2.level < 2'(LEVELS)) && en8[fbit];
		forced8   = {2'b00, alarm_q};
		forced8[fbit] = ctl_s2.forced_alarm;

		usable = ctl_s2.available & ctl_s2.functional;

		res = '0;
		res.status = stm_pkg::STATUS_OK;
		if (ctl_s2.func == stm_pkg::FUNC_FORCED) begin
			res.scaled_value = sat;
			res.value_valid  = 1'b1;
			if (forced_ok) begin
				alarm_d = forced8[NA-1:0];
			end else begin
				alarm_d    = alarm_q;
				res.status = stm_pkg::STATUS_REFUSED;
			end
		end else if (usable) begin
			res.scaled_value = sat;
			res.value_valid  = 1'b1;
			alarm_d          = read_new;
		end else begin
			alarm_d = alarm_q;
		end

		asr = alarm_d & ~alarm_q;
		dsr = alarm_q & ~alarm_d;

		// thresholds are applied in bit order: normal range when a deassert
		// leaves the new low bits and the still untouched high bits all clear
		nr = 1'b0;
		for (int k = 0; k < NA; k++) begin
			low_m = NA'((1 << (k + 1)) - 1);
			if (dsr[k] && ((alarm_d & low_m) == '0) && ((alarm_q & ~low_m) == '0))
				nr = 1'b1;
		end

		res.alarm_bits         = alarm_d;
		res.asserted_events    = asr;
		res.deasserted_events  = dsr;
		res.normal_range_event = nr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q <= '0;
		end else if (upd) begin
			alarm_q <= alarm_d;
		end
	end

endmodule

// ===== sv/sensor_threshold_hysteresis_monitor.sv =====
`timescale 1ns / 1ps
// An accepted word moves through the input, product and result registers to m_axis.
// Throughput: one word per cycle unless m_axis_tready stalls; the alarm flag
//   register loops in the last stage: each word sees its predecessor's flags.
// Reset (arst_n low, asynchronous): pipeline empty, alarms clear, gain 1.0,
//   offset, hysteresis, thresholds and enable mask zero.
// ----------------------------------------------------------------------------
// sensor_threshold_hysteresis_monitor: multi-level alarm with hysteresis
// Scales a raw reading to Q16.16 (raw*gain+offset, saturated), checks 2*LEVELS
// enabled thresholds with hysteresis or applies a forced alarm event, and
// reports the alarm flags with assert, deassert and normal-range events.
// ----------------------------------------------------------------------------
module sensor_threshold_hysteresis_monitor #(
	parameter int LEVELS = stm_pkg::LEVELS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [stm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stm_pkg::PAIR_W-1:0]          cfg_wdata,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// raw_reading[31:0], available[32], functional[33], level[35:34],
	// direction[36], forced_alarm[37], zero [39:38]
	input  logic [stm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// func[0]
	input  logic                                s_axis_tuser,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// scaled_value[31:0], value_valid[32], alarm_bits[38:33],
	// asserted_events[44:39], deasserted_events[50:45],
	// normal_range_event[51], status[52], zero [55:53]
	output logic [stm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int NA = stm_pkg::NUM_ALARMS;

	// ---------------------------------------------------------------- config
	stm_pkg::q16_t                       gain;
	stm_pkg::q16_t                       offset;
	logic [LEVELS-1:0][stm_pkg::Q_W-1:0] hi_th;
	logic [LEVELS-1:0][stm_pkg::Q_W:0]   hi_clr;
	logic [LEVELS-1:0][stm_pkg::Q_W-1:0] lo_th;
	logic [LEVELS-1:0][stm_pkg::Q_W:0]   lo_clr;
	logic [NA-1:0]                       enable;

	stm_cfg_regs #(.LEVELS(LEVELS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.gain      (gain),
		.offset    (offset),
		.hi_th     (hi_th),
		.hi_clr    (hi_clr),
		.lo_th     (lo_th),
		.lo_clr    (lo_clr),
		.enable    (enable)
	);

	// ------------------------------------------------------ pipeline control
	// Each stage loads when it is empty or its successor moves, so bubbles
	// collapse and new words are taken until a waiting result fills all stages.
	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic adv_out;
	logic adv_s2;
	logic adv_s1;

	assign adv_out       = !out_valid_q || m_axis_tready;
	assign adv_s2        = !valid_s2 || adv_out;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	// ---------------------------------------------------- stage 1: input reg
	stm_pkg::q16_t raw_s1;
	stm_pkg::ctl_t ctl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			raw_s1              <= s_axis_tdata[31:0];
			ctl_s1.func         <= s_axis_tuser;
			ctl_s1.available    <= s_axis_tdata[32];
			ctl_s1.functional   <= s_axis_tdata[33];
			ctl_s1.level        <= s_axis_tdata[35:34];
			ctl_s1.direction    <= s_axis_tdata[36];
			ctl_s1.forced_alarm <= s_axis_tdata[37];
		end
	end

	// ------------------------------------------------- stage 2: gain product
	logic signed [stm_pkg::PROD_W-1:0] product_s2;
	stm_pkg::ctl_t                     ctl_s2;

	stm_mult u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv_s2),
		.valid_in   (valid_s1),
		.raw_s1     (raw_s1),
		.ctl_s1     (ctl_s1),
		.gain       (gain),
		.valid_s2   (valid_s2),
		.product_s2 (product_s2),
		.ctl_s2     (ctl_s2)
	);

	// ----------------------------------- stage 3: offset, thresholds, alarms
	// Alarm flags update exactly when a word moves into the result register.
	stm_pkg::res_t res_d;
	stm_pkg::res_t res_q;

	stm_alarm_eval #(.LEVELS(LEVELS)) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (adv_out && valid_s2),
		.product_s2 (product_s2),
		.ctl_s2     (ctl_s2),
		.offset     (offset),
		.hi_th      (hi_th),
		.hi_clr     (hi_clr),
		.lo_th      (lo_th),
		.lo_clr     (lo_clr),
		.enable     (enable),
		.res        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000,
		res_q.status,
		res_q.normal_range_event,
		res_q.deasserted_events,
		res_q.asserted_events,
		res_q.alarm_bits,
		res_q.value_valid,
		res_q.scaled_value};

`ifndef SYNTHESIS
	// a refused forced event changes nothing
	a_refused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == stm_pkg::STATUS_REFUSED) |->
		(res_q.asserted_events == '0 && res_q.deasserted_events == '0))
		else $error("refused forced event reported alarm events");

	// an alarm cannot both assert and deassert in one word
	a_events_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((res_q.asserted_events & res_q.deasserted_events) == '0))
		else $error("alarm both asserted and deasserted");

	// normal range comes only with a deassert; a later bit in the walk may
	// still assert, so the final flags need not be clear
	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.normal_range_event) |->
		(res_q.deasserted_events != '0))
		else $error("normal-range event without a deassert");

	// an unusable reading yields zero value and leaves alarms alone
	a_unusable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.value_valid) |->
		(res_q.scaled_value == '0 && res_q.asserted_events == '0 &&
		 res_q.deasserted_events == '0))
		else $error("unusable reading changed alarms or value");

	// the alarm flags reported follow from the events of this word
	a_flags_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (((res_q.alarm_bits & res_q.asserted_events) ==
		res_q.asserted_events) && ((res_q.alarm_bits & res_q.deasserted_events) == '0)))
		else $error("alarm flags disagree with reported events");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sensor_threshold_hysteresis_monitor
// A directed table (reset settings, then a fixed threshold ladder) and
// phases of random words under changing settings go through the stream
// ports. A predictor in the bench works out every result word but the
// typed table rows, and each word from the block is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

	localparam int LEVELS        = stm_pkg::LEVELS_DEFAULT;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_WORDS   = 70;
	localparam int TAIL_CYCLES   = 8;       // result path is three registers deep

	// short names for the directed table columns
	localparam logic RD = stm_pkg::FUNC_READING;
	localparam logic FC = stm_pkg::FUNC_FORCED;
	localparam logic OK = stm_pkg::STATUS_OK;
	localparam logic RF = stm_pkg::STATUS_REFUSED;

	// one input word, unpacked into its fields
	typedef struct packed {
		logic        func;
		logic [31:0] raw;
		logic        avail;
		logic        fn_ok;
		logic [1:0]  level;
		logic        dir;
		logic        forced;
	} word_in_t;

	// directed row: typed rows carry their expected value/valid/status
	typedef struct packed {
		word_in_t    w;
		bit          typed;
		logic [31:0] t_value;
		logic        t_valid;
		logic        t_status;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [stm_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [stm_pkg::PAIR_W-1:0]      cfg_wdata;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [stm_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                            s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [stm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	// predictor copy of settings and alarm flags
	logic [5:0] flags_now;
	longint     k_gain, k_offset, k_band;
	longint     k_hi [3];
	longint     k_lo [3];
	logic [5:0] k_mask;

	stm_pkg::res_t pending_results [$];
	dir_row_t      dir_rows [$];
	bit            calm;       // no idling on either side this phase
	int            errors, cycles, words_sent, words_checked;
	int            n_assert, n_deassert, n_clear, n_refused;

	sensor_threshold_hysteresis_monitor #(
		.LEVELS(LEVELS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("sensor_threshold_hysteresis_monitor test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic longint sx(input logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// raw*gain+offset is exact in 64 bits before clamping
	function automatic longint scaled_q(input logic [31:0] raw);
		return sat32(sx(raw) * k_gain + k_offset);
	endfunction

	function automatic void flip_alarm(input int b, input logic nv,
			inout stm_pkg::res_t r);
		if (flags_now[b] != nv) begin
			flags_now[b] = nv;
			if (nv) begin
				r.asserted_events[b] = 1'b1;
			end else begin
				r.deasserted_events[b] = 1'b1;
				// all-clear is judged at this point of the bit walk
				if (flags_now == '0)
					r.normal_range_event = 1'b1;
			end
		end
	endfunction

	function automatic stm_pkg::res_t predict_alarm_word(input word_in_t w);
		stm_pkg::res_t r;
		longint        v, th;
		logic [5:0]    en;
		logic          nv;
		int            b;
		r = '0;
		// levels past LEVELS never take part
		en = k_mask & 6'((1 << (2 * LEVELS)) - 1);
		if (w.func == stm_pkg::FUNC_READING) begin
			if (w.avail && w.fn_ok) begin
				v = scaled_q(w.raw);
				r.value_valid = 1'b1;
				r.scaled_value = v[31:0];
				// walk order: warn hi, warn lo, crit hi, crit lo, shut hi, shut lo
				for (b = 0; b < stm_pkg::NUM_ALARMS; b++) begin
					if (en[b]) begin
						th = b[0] ? k_lo[b / 2] : k_hi[b / 2];
						nv = flags_now[b];
						if (!b[0]) begin
							if (v >= th)
								nv = 1'b1;
							else if (v < th - k_band)
								nv = 1'b0;
						end else begin
							if (v <= th)
								nv = 1'b1;
							else if (v > th + k_band)
								nv = 1'b0;
						end
						flip_alarm(b, nv, r);
					end
				end
			end
		end else begin
			v = scaled_q(w.raw);
			r.value_valid = 1'b1;
			r.scaled_value = v[31:0];
			b = 2 * int'(w.level) + int'(w.dir);
			if (int'(w.level) >= LEVELS)
				r.status = stm_pkg::STATUS_REFUSED;
			else if (!en[b])
				r.status = stm_pkg::STATUS_REFUSED;
			else
				flip_alarm(b, w.forced, r);
		end
		r.alarm_bits = flags_now;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
			words_checked);
		errors++;
	endtask

	task automatic check_word(input stm_pkg::res_t got);
		stm_pkg::res_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result with nothing pending", 64'(got), 64'd0);
		end else begin
			want = pending_results.pop_front();
			if (got.scaled_value !== want.scaled_value)
				report_mismatch("scaled_value", 64'(got.scaled_value),
					64'(want.scaled_value));
			if (got.value_valid !== want.value_valid)
				report_mismatch("value_valid", 64'(got.value_valid),
					64'(want.value_valid));
			if (got.alarm_bits !== want.alarm_bits)
				report_mismatch("alarm_bits", 64'(got.alarm_bits),
					64'(want.alarm_bits));
			if (got.asserted_events !== want.asserted_events)
				report_mismatch("asserted_events", 64'(got.asserted_events),
					64'(want.asserted_events));
			if (got.deasserted_events !== want.deasserted_events)
				report_mismatch("deasserted_events", 64'(got.deasserted_events),
					64'(want.deasserted_events));
			if (got.normal_range_event !== want.normal_range_event)
				report_mismatch("normal_range_event", 64'(got.normal_range_event),
					64'(want.normal_range_event));
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			n_assert   += int'(want.asserted_events != '0);
			n_deassert += int'(want.deasserted_events != '0);
			n_clear    += int'(want.normal_range_event);
			n_refused  += int'(want.status == stm_pkg::STATUS_REFUSED);
		end
		words_checked++;
	endtask

	// results are sampled at the rising edge, before the edge's updates land
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_word(m_axis_tdata[$bits(stm_pkg::res_t)-1:0]);
	end

	// ------------------------------------------------------------------
	// stream drivers; all inputs change on the falling edge
	// ------------------------------------------------------------------
	function automatic int idle_draw();
		if (calm)
			return 0;
		return ($urandom_range(0, 1) != 0) ? 0 : int'($urandom_range(0, 16));
	endfunction

	// result side: random stall before each word
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		forever begin
			@(negedge clk);
			stall = idle_draw();
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
		end
	end

	// called and left on a falling edge; tvalid stays high into the next word
	// when there is no gap, so it is never lowered and raised in one step
	task automatic send_word(input word_in_t w, input bit typed,
			input stm_pkg::res_t typed_res);
		int            gap;
		stm_pkg::res_t want;
		gap = idle_draw();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= w.func;
		s_axis_tdata  <= {2'b00, w.forced, w.dir, w.level, w.fn_ok, w.avail, w.raw};
		do @(posedge clk); while (!s_axis_tready);
		// predictor runs on every accepted word so the flags stay in step
		want = predict_alarm_word(w);
		pending_results.push_back(typed ? typed_res : want);
		words_sent++;
		@(negedge clk);
	endtask

	// stream goes quiet and every result comes back before settings change
	task automatic finish_phase();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// settings
	// ------------------------------------------------------------------
	task automatic put_reg(input logic [stm_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(negedge clk);
	endtask

	// every register each time; unused upper bits carry junk
	task automatic load_settings();
		logic [63:0] d;
		int          i;
		d = {$urandom(), $urandom()};
		d[31:0] = k_gain[31:0];
		put_reg(stm_pkg::REG_GAIN, d);
		d = {$urandom(), $urandom()};
		d[31:0] = k_offset[31:0];
		put_reg(stm_pkg::REG_OFFSET, d);
		d = {$urandom(), $urandom()};
		d[30:0] = k_band[30:0];
		put_reg(stm_pkg::REG_HYST, d);
		for (i = 0; i < 3; i++)
			put_reg(stm_pkg::REG_WARNING_PAIR + 3'(i), {k_hi[i][31:0], k_lo[i][31:0]});
		d = {$urandom(), $urandom()};
		d[5:0] = k_mask;
		put_reg(stm_pkg::REG_ENABLE_MASK, d);
		cfg_we <= 1'b0;
	endtask

	task automatic pick_settings(input int p);
		longint hi, lo;
		int     i;
		// default: ordered ladder around a random center, gain 1 LSB so
		// band edges can be hit exactly
		hi = longint'($urandom_range(0, 32'h0200_0000)) - 64'sd16777216;
		lo = hi;
		for (i = 0; i < 3; i++) begin
			hi += longint'($urandom_range(1, 32'h0010_0000));
			lo -= longint'($urandom_range(1, 32'h0010_0000));
			k_hi[i] = hi;
			k_lo[i] = lo;
		end
		k_band   = longint'($urandom_range(0, 32'h0004_0000));
		k_gain   = 1;
		k_offset = longint'($urandom_range(0, 32'h0100_0000)) - 64'sd8388608;
		k_mask   = 6'($urandom_range(0, 63));
		case (p)
			0: begin
				k_mask   = '1;
				k_offset = 0;
			end
			1: begin
				// unit gain, coarse steps
				k_gain   = 65536;
				k_offset = 0;
				k_mask   = '1;
			end
			2: begin
				// extremes everywhere
				k_gain   = 64'sd2147483647;
				k_offset = -64'sd2147483648;
				k_band   = 64'sd2147483647;
				k_hi[0]  = 64'sd2147483647;
				k_lo[0]  = -64'sd2147483648;
				k_hi[2]  = -64'sd2147483648;
				k_lo[2]  = 64'sd2147483647;
				k_mask   = '1;
			end
			3: begin
				k_gain   = -64'sd2147483648;
				k_offset = 64'sd2147483647;
				k_band   = 0;
				k_mask   = '1;
			end
			4: begin
				// nothing enabled: forced events all refused
				k_gain = 0;
				k_mask = '0;
			end
			5: begin
				k_gain = -longint'($urandom_range(1, 4));
				k_mask = '1;
			end
			6: begin
				// unordered thresholds, wide band, any gain
				for (i = 0; i < 3; i++) begin
					k_hi[i] = sx($urandom());
					k_lo[i] = sx($urandom());
				end
				k_band = longint'($urandom_range(0, 32'h7FFF_FFFF));
				k_gain = sx($urandom());
				k_mask = '1;
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// random words: mostly readings aimed at a threshold or its band edge
	// ------------------------------------------------------------------
	function automatic word_in_t random_word();
		word_in_t w;
		int       pick, b;
		longint   th, tgt;
		w.func   = stm_pkg::FUNC_READING;
		w.raw    = $urandom();
		w.avail  = 1'b1;
		w.fn_ok  = 1'b1;
		w.level  = 2'($urandom_range(0, 3));
		w.dir    = 1'($urandom_range(0, 1));
		w.forced = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			w.func  = stm_pkg::FUNC_FORCED;
			w.avail = 1'($urandom_range(0, 1));
			w.fn_ok = 1'($urandom_range(0, 1));
		end else if (pick < 30) begin
			// noise, sometimes unusable
			w.avail = ($urandom_range(0, 3) != 0);
			w.fn_ok = ($urandom_range(0, 3) != 0);
		end else begin
			b  = $urandom_range(0, 5);
			th = b[0] ? k_lo[b / 2] : k_hi[b / 2];
			case ($urandom_range(0, 7))
				0: tgt = th;
				1: tgt = th - k_band;
				2: tgt = th - k_band - 1;
				3: tgt = th + k_band;
				4: tgt = th + k_band + 1;
				5: tgt = th - 1;
				6: tgt = th + 1;
				default: tgt = th - k_band - 16
					+ longint'($urandom()) % (2 * k_band + 33);
			endcase
			if (k_gain != 0)
				w.raw = 32'(sat32((tgt - k_offset) / k_gain));
		end
		return w;
	endfunction

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------
	function automatic void add_row(input logic func, input logic [31:0] raw,
			input logic avail, input logic fn_ok, input logic [1:0] level,
			input logic dir, input logic forced, input bit typed,
			input logic [31:0] value, input logic valid, input logic status);
		dir_row_t r;
		r.w = '{func, raw, avail, fn_ok, level, dir, forced};
		r.typed    = typed;
		r.t_value  = value;
		r.t_valid  = valid;
		r.t_status = status;
		dir_rows.push_back(r);
	endfunction

	task automatic play_rows();
		dir_row_t      r;
		stm_pkg::res_t t;
		while (dir_rows.size() != 0) begin
			r = dir_rows.pop_front();
			// typed rows only occur with the mask clear: flags and events stay 0
			t = '0;
			t.scaled_value = r.t_value;
			t.value_valid  = r.t_valid;
			t.status       = r.t_status;
			send_word(r.w, r.typed, t);
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int i, p;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= stm_pkg::FUNC_READING;
		words_sent = 0;
		calm = 1'b0;
		flags_now = '0;
		k_gain = 65536;
		k_offset = 0;
		k_band = 0;
		for (i = 0; i < 3; i++) begin
			k_hi[i] = 0;
			k_lo[i] = 0;
		end
		k_mask = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: gain 1.0, nothing enabled
		//      fn  raw            av    fn    lv    dr    fa    typ   value          vld   st
		add_row(RD, 32'd0,         1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 1'b1, OK);
		add_row(RD, 32'd32767,     1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b1, 32'h7FFF_0000, 1'b1, OK);
		add_row(RD, 32'd32768,     1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1, OK);
		add_row(RD, 32'hFFFF_8000, 1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 1'b1, OK);
		add_row(RD, 32'hFFFF_7FFF, 1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 1'b1, OK);
		add_row(RD, 32'h7FFF_FFFF, 1'b1, 1'b1, 2'd3, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, OK);
		add_row(RD, 32'h8000_0000, 1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 1'b1, OK);
		// unusable readings
		add_row(RD, 32'd5,         1'b0, 1'b1, 2'd0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 1'b0, OK);
		add_row(RD, 32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 1'b0, OK);
		// forced events refused: threshold disabled, level out of range
		add_row(FC, 32'd2,         1'b1, 1'b1, 2'd0, 1'b0, 1'b1, 1'b1, 32'h0002_0000, 1'b1, RF);
		add_row(FC, 32'hFFFF_FFFE, 1'b0, 1'b0, 2'd3, 1'b1, 1'b1, 1'b1, 32'hFFFE_0000, 1'b1, RF);
		play_rows();
		finish_phase();

		// ladder: warn +-10, crit +-20, shutdown +-30, band 2.0, all enabled
		k_gain   = 65536;
		k_offset = 0;
		k_band   = 64'sd131072;
		for (i = 0; i < 3; i++) begin
			k_hi[i] = longint'(i + 1) * 655360;
			k_lo[i] = -longint'(i + 1) * 655360;
		end
		k_mask = '1;
		load_settings();
		add_row(RD, 32'd0,         1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK);
		add_row(RD, 32'd10,        1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK); // on hi
		add_row(RD, 32'd9,         1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK); // holds
		add_row(RD, 32'd8,         1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK); // band
		add_row(RD, 32'd7,         1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK); // clear
		add_row(RD, 32'd30,        1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK); // 3 hi
		add_row(RD, 32'd27,        1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK);
		add_row(RD, 32'd0,         1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK);
		add_row(RD, 32'hFFFF_FFE2, 1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK); // 3 lo
		add_row(RD, 32'd40,        1'b0, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK);
		// forced: clear crit lo, repeat it (no event), set warn hi
		add_row(FC, 32'd3,         1'b0, 1'b0, 2'd1, 1'b1, 1'b0, 1'b0, '0, 1'b0, OK);
		add_row(FC, 32'd3,         1'b0, 1'b0, 2'd1, 1'b1, 1'b0, 1'b0, '0, 1'b0, OK);
		add_row(FC, 32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0, 1'b0, 1'b1, 1'b0, '0, 1'b0, OK);
		add_row(RD, 32'd0,         1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, OK);
		play_rows();
		finish_phase();

		// random phases, each under fresh settings
		for (p = 0; p < RANDOM_PHASES; p++) begin
			pick_settings(p);
			load_settings();
			calm = (p == 0 || p == 5);
			repeat (PHASE_WORDS)
				send_word(random_word(), 1'b0, '0);
			finish_phase();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", 64'(pending_results.size()), 64'd0);

		$display("%0d words sent, %0d results checked over %0d setting phases",
			words_sent, words_checked, RANDOM_PHASES + 2);
		$display("results with asserts %0d, deasserts %0d, all-clear %0d, refused %0d",
			n_assert, n_deassert, n_clear, n_refused);
		if (errors == 0) begin
			$display("sensor_threshold_hysteresis_monitor test passed");
		end else begin
			$display("sensor_threshold_hysteresis_monitor test failed");
		end
		$finish;
	end

endmodule
